// File: rtl/bpa_pkg.sv
// bitmap page allocator package: types, constants and opcodes
// no dependencies
`timescale 1ns / 1ps
package bpa_pkg;

    localparam int MaxPages  = 65536;
    localparam int PageShift = 12;
    localparam int IdxW      = $clog2(MaxPages);
    localparam int CntW      = IdxW + 1;
    localparam int WordW     = 64;
    localparam int WordSel   = $clog2(WordW);
    localparam int Words     = MaxPages / WordW;
    localparam int AddrW     = IdxW - WordSel;

    localparam logic [2:0] OP_REQUEST   = 3'd0;
    localparam logic [2:0] OP_FREE      = 3'd1;
    localparam logic [2:0] OP_LOCK      = 3'd2;
    localparam logic [2:0] OP_UNLOCK    = 3'd3;
    localparam logic [2:0] OP_RESERVE   = 3'd4;
    localparam logic [2:0] OP_UNRESERVE = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_PAGES = 1'b1;

    typedef struct packed {
        logic [2:0]      opcode;
        logic [15:0]     page_index;
        logic [16:0]     page_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [63:0]     page_address;
        logic [16:0]     free_pages;
        logic [16:0]     locked_pages;
        logic [16:0]     reserved_pages;
    } out_item_t;

    // memory port from engine to bitmap
    typedef struct packed {
        logic             rd;
        logic [AddrW-1:0] raddr;
        logic             wr;
        logic [AddrW-1:0] waddr;
        logic [WordW-1:0] wdata;
    } mem_req_t;

endpackage

// File: rtl/bpa_bitmap.sv
// bitmap word memory, registered read, cleared by a pass after reset
// depends on bpa_pkg
`timescale 1ns / 1ps
module bpa_bitmap
    import bpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mem_req_t         req,
    output logic [WordW-1:0] rdata,
    output logic             busy
);

    logic [WordW-1:0] mem [Words];
    logic [WordW-1:0] q_reg;
    logic [AddrW-1:0] clr_addr_reg;
    logic             clr_busy_reg;

    // storage, no reset; the clearing pass has the write port first
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (req.wr)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.rd)
        begin
            q_reg <= mem[req.raddr];
        end
    end

    // clearing pass over every word after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AddrW'(1);
            if (clr_addr_reg == AddrW'(Words - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign rdata = q_reg;
    assign busy  = clr_busy_reg;

endmodule

// File: rtl/bpa_engine.sv
// operation sequencer: next-fit scan and run updates over bitmap words
// depends on bpa_pkg
`timescale 1ns / 1ps
module bpa_engine
    import bpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    input  logic [63:0]      base_address,
    input  logic [CntW-1:0]  total,
    input  logic             cfg_pages_wr,
    input  logic [CntW-1:0]  cfg_total,
    output mem_req_t         mreq,
    input  logic [WordW-1:0] rdata,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item
);

    typedef enum logic [2:0] {
        S_IDLE, S_SREAD, S_SCHK, S_RREAD, S_RMOD, S_DONE
    } state_t;

    state_t            state_reg;
    logic [2:0]        op_reg;
    logic [IdxW-1:0]   ptr_reg;
    logic [IdxW-1:0]   scan_reg;
    logic [CntW-1:0]   left_reg;
    logic [CntW-1:0]   pos_reg;
    logic [CntW-1:0]   n_reg;
    logic [CntW-1:0]   free_reg, lock_reg, resv_reg;
    logic              ov_reg;
    out_item_t         out_reg;

    // per-word scan helpers
    logic [WordSel-1:0] bitpos;
    logic [WordSel:0]   chunk;
    logic [CntW-1:0]    wrap_end;
    logic [WordW-1:0]   cand;
    logic               hit;
    logic [WordSel-1:0] hit_bit;
    logic [IdxW-1:0]    hit_page;
    logic [CntW-1:0]    word_left;
    logic [WordW-1:0]   rmask;
    logic [WordSel:0]   rchunk;
    logic               set_op;
    logic [CntW:0]      sum_add;
    logic [CntW-1:0]    nn;
    logic [CntW-1:0]    cap;

    assign cap    = CntW'(MaxPages);
    assign bitpos = scan_reg[WordSel-1:0];
    assign set_op = (op_reg == OP_LOCK) || (op_reg == OP_RESERVE);

    // scan: pages from bitpos up to word end, bounded by wrap point and pages left
    always_comb
    begin
        word_left = CntW'(WordW) - CntW'(bitpos);
        wrap_end  = total - CntW'(scan_reg);
        if (wrap_end < word_left) word_left = wrap_end;
        if (left_reg < word_left) word_left = left_reg;
        chunk = word_left[WordSel:0];
        cand  = '0;
        for (int i = 0; i < WordW; i++)
        begin
            if (i >= int'(bitpos) && i < int'(bitpos) + int'(chunk))
                cand[i] = ~rdata[i];
        end
        hit     = |cand;
        hit_bit = '0;
        for (int i = WordW - 1; i >= 0; i--)
        begin
            if (cand[i]) hit_bit = WordSel'(i);
        end
        hit_page = {scan_reg[IdxW-1:WordSel], hit_bit};
    end

    // run: mask of pages touched in this word
    always_comb
    begin
        rchunk = (pos_reg < CntW'(WordW) - CntW'(bitpos))
                 ? pos_reg[WordSel:0] : (WordSel+1)'(WordW) - (WordSel+1)'(bitpos);
        rmask  = '0;
        for (int i = 0; i < WordW; i++)
        begin
            if (i >= int'(bitpos) && i < int'(bitpos) + int'(rchunk))
                rmask[i] = 1'b1;
        end
    end

    // memory requests
    always_comb
    begin
        mreq       = '0;
        mreq.raddr = scan_reg[IdxW-1:WordSel];
        mreq.waddr = scan_reg[IdxW-1:WordSel];
        mreq.rd    = (state_reg == S_SREAD) || (state_reg == S_RREAD);
        if (state_reg == S_SCHK && hit)
        begin
            mreq.wr    = 1'b1;
            mreq.wdata = rdata | (WordW'(1) << hit_bit);
        end
        if (state_reg == S_RMOD)
        begin
            mreq.wr    = 1'b1;
            mreq.wdata = set_op ? (rdata | rmask) : (rdata & ~rmask);
        end
    end

    assign nn      = (in_item.opcode == OP_FREE) ? CntW'(1) : in_item.page_count;
    assign sum_add = {1'b0, CntW'(in_item.page_index)} + {1'b0, nn};

    function automatic logic [CntW-1:0] sadd(input logic [CntW-1:0] a,
                                            input logic [CntW-1:0] b,
                                            input logic [CntW-1:0] m);
        logic [CntW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, m}) ? m : s[CntW-1:0];
    endfunction

    function automatic logic [CntW-1:0] ssub(input logic [CntW-1:0] a,
                                            input logic [CntW-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            free_reg  <= CntW'(MaxPages);
            lock_reg  <= '0;
            resv_reg  <= '0;
            ov_reg    <= 1'b0;
            op_reg    <= '0;
            scan_reg  <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
            n_reg     <= '0;
            out_reg   <= '0;
        end
        else
        begin
            if (out_ready) ov_reg <= 1'b0;
            if (cfg_pages_wr) free_reg <= cfg_total;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !ov_reg)
                    begin
                        op_reg  <= in_item.opcode;
                        out_reg <= '0;
                        if (in_item.opcode == OP_REQUEST)
                        begin
                            scan_reg  <= (CntW'(ptr_reg) < total) ? ptr_reg : '0;
                            left_reg  <= total;
                            state_reg <= (total == '0) ? S_DONE : S_SREAD;
                            out_reg.status <= (total == '0) ? ST_FULL : ST_OK;
                        end
                        else if (in_item.opcode > OP_UNRESERVE)
                        begin
                            state_reg <= S_DONE;
                        end
                        else if (sum_add > {1'b0, total})
                        begin
                            out_reg.status <= ST_RANGE;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            scan_reg  <= in_item.page_index;
                            pos_reg   <= nn;
                            n_reg     <= nn;
                            state_reg <= (nn == '0) ? S_DONE : S_RREAD;
                        end
                    end
                end
                S_SREAD: state_reg <= S_SCHK;
                S_SCHK:
                begin
                    if (hit)
                    begin
                        ptr_reg  <= hit_page;
                        free_reg <= ssub(free_reg, CntW'(1));
                        lock_reg <= sadd(lock_reg, CntW'(1), cap);
                        out_reg.page_address <= base_address
                            + (64'(hit_page) << PageShift);
                        state_reg <= S_DONE;
                    end
                    else if (left_reg == CntW'(chunk))
                    begin
                        out_reg.status <= ST_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        left_reg  <= left_reg - CntW'(chunk);
                        scan_reg  <= (CntW'(scan_reg) + CntW'(chunk) >= total)
                                     ? '0 : scan_reg + IdxW'(chunk);
                        state_reg <= S_SREAD;
                    end
                end
                S_RREAD: state_reg <= S_RMOD;
                S_RMOD:
                begin
                    pos_reg  <= pos_reg - CntW'(rchunk);
                    scan_reg <= scan_reg + IdxW'(rchunk);
                    if (pos_reg == CntW'(rchunk))
                    begin
                        state_reg <= S_DONE;
                        free_reg  <= set_op ? ssub(free_reg, n_reg)
                                            : sadd(free_reg, n_reg, cap);
                        case (op_reg)
                            OP_LOCK:      lock_reg <= sadd(lock_reg, n_reg, cap);
                            OP_FREE,
                            OP_UNLOCK:    lock_reg <= ssub(lock_reg, n_reg);
                            OP_RESERVE:   resv_reg <= sadd(resv_reg, n_reg, cap);
                            default:      resv_reg <= ssub(resv_reg, n_reg);
                        endcase
                    end
                    else
                    begin
                        state_reg <= S_RREAD;
                    end
                end
                S_DONE:
                begin
                    out_reg.free_pages     <= free_reg;
                    out_reg.locked_pages   <= lock_reg;
                    out_reg.reserved_pages <= resv_reg;
                    ov_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/bitmap_page_allocator.sv
// bitmap page allocator: request and run items step through each bitmap word touched, a read
// state and then a check or modify state, and the result is registered in a done state
// (a full scan of 65536 pages from mid-word touches 1025 words)
// one item at a time, result held in an output register until taken
// reset: clearing pass over the 1024 bitmap words with input held off, counters and pointer
// cleared, free count set to the managed pages; depends on bpa_pkg, bpa_bitmap, bpa_engine
`timescale 1ns / 1ps
module bitmap_page_allocator
    import bpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0]      base_reg;
    logic [16:0]      pages_reg;
    logic [CntW-1:0]  total;
    logic [CntW-1:0]  cfg_total;
    mem_req_t         mreq;
    logic [WordW-1:0] rdata;
    logic             map_busy;
    logic             eng_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            pages_reg <= 17'd65536;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_BASE) base_reg <= cfg_data;
            else                       pages_reg <= cfg_data[16:0];
        end
    end

    assign total = (pages_reg > 17'(MaxPages)) ? CntW'(MaxPages) : CntW'(pages_reg);

    // managed page count of the value being written
    assign cfg_total = (cfg_data[16:0] > 17'(MaxPages)) ? CntW'(MaxPages)
                                                        : CntW'(cfg_data[16:0]);

    // input held off while the bitmap is being cleared
    assign in_ready = eng_ready && !map_busy;

    bpa_bitmap u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rdata (rdata),
        .busy  (map_busy)
    );

    bpa_engine u_eng (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid && !map_busy),
        .in_ready     (eng_ready),
        .in_item      (in_item),
        .base_address (base_reg),
        .total        (total),
        .cfg_pages_wr (cfg_we && cfg_index == REG_PAGES),
        .cfg_total    (cfg_total),
        .mreq         (mreq),
        .rdata        (rdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_item     (out_item)
    );

endmodule

// File: verif/bitmap_page_allocator_tb.sv
// testbench for the bitmap page allocator: random and directed items with a bit-exact predictor
// depends on bpa_pkg and bitmap_page_allocator
`timescale 1ns / 1ps
module bitmap_page_allocator_tb;
    import bpa_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = REG_BASE;
    logic [63:0] cfg_data  = '0;

    // allocator shadow state
    logic [63:0] shadow_base;
    int          shadow_avail;
    bit          page_used [MaxPages];
    int          next_fit_ptr;
    int          free_cnt;
    int          locked_cnt;
    int          reserved_cnt;

    in_item_t    pending_items [$];
    out_item_t   expected_results [$];
    int          errors = 0;

    bitmap_page_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int managed_pages();
        return (shadow_avail > MaxPages) ? MaxPages : shadow_avail;
    endfunction

    function automatic int sat_up(int a, int n);
        return (a + n > MaxPages) ? MaxPages : a + n;
    endfunction

    function automatic int sat_down(int a, int n);
        return (a > n) ? a - n : 0;
    endfunction

    // work out the result of one accepted item and update the shadow state
    function automatic out_item_t allocate_or_update(in_item_t it);
        out_item_t r;
        int        total;
        int        p;
        int        n;
        bit        found;
        bit        set_bits;
        total = managed_pages();
        r = '0;
        r.status = ST_OK;
        if (it.opcode == OP_REQUEST)
        begin
            p = (next_fit_ptr < total) ? next_fit_ptr : 0;
            found = 1'b0;
            for (int k = 0; k < total; k++)
            begin
                if (!page_used[p])
                begin
                    found = 1'b1;
                    break;
                end
                p++;
                if (p >= total)
                    p = 0;
            end
            if (found)
            begin
                page_used[p] = 1'b1;
                free_cnt = sat_down(free_cnt, 1);
                locked_cnt = sat_up(locked_cnt, 1);
                next_fit_ptr = p;
                r.page_address = shadow_base + (64'(p) << PageShift);
            end
            else
                r.status = ST_FULL;
        end
        else if (it.opcode <= OP_UNRESERVE)
        begin
            n = (it.opcode == OP_FREE) ? 1 : int'(it.page_count);
            if (int'(it.page_index) + n > total)
                r.status = ST_RANGE;
            else
            begin
                set_bits = (it.opcode == OP_LOCK || it.opcode == OP_RESERVE);
                for (int i = 0; i < n; i++)
                    page_used[int'(it.page_index) + i] = set_bits;
                free_cnt = set_bits ? sat_down(free_cnt, n) : sat_up(free_cnt, n);
                case (it.opcode)
                    OP_LOCK:                locked_cnt = sat_up(locked_cnt, n);
                    OP_FREE, OP_UNLOCK:     locked_cnt = sat_down(locked_cnt, n);
                    OP_RESERVE:             reserved_cnt = sat_up(reserved_cnt, n);
                    default:                reserved_cnt = sat_down(reserved_cnt, n);
                endcase
            end
        end
        r.free_pages     = 17'(free_cnt);
        r.locked_pages   = 17'(locked_cnt);
        r.reserved_pages = 17'(reserved_cnt);
        return r;
    endfunction

    // driver: bursts of items with random gaps
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_item  <= pending_items.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(30, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stalls, quiet stretches and one long hold-off
    int  rx_cycle   = 0;
    int  rx_taken   = 0;
    int  hold_left  = 0;
    bit  held_once  = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (out_valid && out_ready)
                rx_taken <= rx_taken + 1;
            if (!held_once && rx_taken == 400)
            begin
                held_once <= 1'b1;
                hold_left <= 400;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if ((rx_cycle / 300) % 3 == 2)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(3, 0) != 0);
        end
    end

    // monitor: check results, then predict for accepted items
    out_item_t exp_r;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%t: unexpected result, actual %p", $realtime, out_item);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_item.status !== exp_r.status)
                begin
                    $display("%t: status expected %0d actual %0d",
                             $realtime, exp_r.status, out_item.status);
                    errors++;
                end
                if (out_item.page_address !== exp_r.page_address)
                begin
                    $display("%t: page_address expected %h actual %h",
                             $realtime, exp_r.page_address, out_item.page_address);
                    errors++;
                end
                if (out_item.free_pages !== exp_r.free_pages)
                begin
                    $display("%t: free_pages expected %0d actual %0d",
                             $realtime, exp_r.free_pages, out_item.free_pages);
                    errors++;
                end
                if (out_item.locked_pages !== exp_r.locked_pages)
                begin
                    $display("%t: locked_pages expected %0d actual %0d",
                             $realtime, exp_r.locked_pages, out_item.locked_pages);
                    errors++;
                end
                if (out_item.reserved_pages !== exp_r.reserved_pages)
                begin
                    $display("%t: reserved_pages expected %0d actual %0d",
                             $realtime, exp_r.reserved_pages, out_item.reserved_pages);
                    errors++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
            expected_results.push_back(allocate_or_update(in_item));
    end

    function automatic in_item_t make_item(logic [2:0] op, int idx, int cnt);
        in_item_t it;
        it.opcode     = op;
        it.page_index = 16'(idx);
        it.page_count = 17'(cnt);
        return it;
    endfunction

    // random items for one setting, mostly small runs inside the managed range
    task automatic queue_random(int n_items, int total);
        int         pick;
        int         idx;
        int         cnt;
        int         room;
        logic [2:0] op;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(99, 0);
            idx  = (total > 0) ? $urandom_range(total - 1, 0) : $urandom_range(65535, 0);
            room = total - idx;
            cnt  = (room > 0) ? $urandom_range((room < 70) ? room : 70, 1) : 1;
            op   = 3'($urandom_range(5, 2));
            if (pick < 35)
                op = OP_REQUEST;
            else if (pick < 50)
                op = OP_FREE;
            else if (pick < 52)
                cnt = 0;
            else if (pick < 55)
                op = 3'($urandom_range(7, 6));
            else if (pick < 60)
            begin
                idx = $urandom_range(65535, 0);
                cnt = $urandom_range(65536, 1);
            end
            else if (pick < 61 && room > 0)
                cnt = room;
            pending_items.push_back(make_item(op, idx, cnt));
        end
    endtask

    // idle is judged between edges, once every process of the edge has settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_BASE)
            shadow_base = value;
        else
        begin
            shadow_avail = int'(value[16:0]);
            free_cnt = managed_pages();
        end
    endtask

    function automatic logic [63:0] random_base();
        return {$urandom, $urandom} & ~64'hFFF;
    endfunction

    initial
    begin
        shadow_base  = '0;
        shadow_avail = 65536;
        next_fit_ptr = 0;
        free_cnt     = MaxPages;
        locked_cnt   = 0;
        reserved_cnt = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every operation, empty run, saturation, full memory, range edges
        pending_items.push_back(make_item(OP_REQUEST, 0, 1));
        pending_items.push_back(make_item(OP_FREE, 0, 1));
        pending_items.push_back(make_item(OP_LOCK, 0, 1));
        pending_items.push_back(make_item(OP_UNLOCK, 0, 1));
        pending_items.push_back(make_item(OP_RESERVE, 65535, 1));
        pending_items.push_back(make_item(OP_UNRESERVE, 65535, 1));
        pending_items.push_back(make_item(OP_UNRESERVE, 100, 5));
        pending_items.push_back(make_item(OP_RESERVE, 0, 0));
        pending_items.push_back(make_item(3'd6, 12, 3));
        pending_items.push_back(make_item(3'd7, 65535, 65536));
        pending_items.push_back(make_item(OP_LOCK, 65535, 2));
        pending_items.push_back(make_item(OP_LOCK, 1, 65536));
        pending_items.push_back(make_item(OP_FREE, 65535, 99));
        pending_items.push_back(make_item(OP_LOCK, 0, 65536));
        pending_items.push_back(make_item(OP_REQUEST, 0, 1));
        pending_items.push_back(make_item(OP_LOCK, 0, 65536));
        pending_items.push_back(make_item(OP_UNLOCK, 0, 65536));
        pending_items.push_back(make_item(OP_RESERVE, 0, 65536));
        pending_items.push_back(make_item(OP_RESERVE, 0, 65536));
        pending_items.push_back(make_item(OP_UNRESERVE, 0, 65536));
        pending_items.push_back(make_item(OP_UNRESERVE, 0, 65536));
        pending_items.push_back(make_item(OP_REQUEST, 0, 1));
        pending_items.push_back(make_item(OP_REQUEST, 0, 1));
        queue_random(300, 65536);
        wait_idle();

        // several settings, extremes among them
        write_reg(REG_BASE, random_base());
        write_reg(REG_PAGES, 64'd64);
        queue_random(300, 64);
        wait_idle();
        write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF_F000);
        write_reg(REG_PAGES, 64'd1);
        queue_random(100, 1);
        wait_idle();
        write_reg(REG_PAGES, 64'd0);
        queue_random(30, 0);
        wait_idle();
        write_reg(REG_BASE, random_base());
        write_reg(REG_PAGES, 64'd200);
        queue_random(300, 200);
        wait_idle();
        write_reg(REG_BASE, random_base());
        write_reg(REG_PAGES, 64'd65536);
        queue_random(300, 65536);
        wait_idle();
        write_reg(REG_BASE, 64'd0);
        write_reg(REG_PAGES, 64'd1000);
        queue_random(300, 1000);
        wait_idle();

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("bitmap_page_allocator_tb OK");
        else
            $display("bitmap_page_allocator_tb NOT OK");
        $finish;
    end

    // run limit
    initial
    begin
        #200_000_000;
        $display("bitmap_page_allocator_tb NOT OK");
        $finish;
    end

endmodule

// File: bitmap_page_allocator.f
rtl/bpa_pkg.sv
rtl/bpa_bitmap.sv
rtl/bpa_engine.sv
rtl/bitmap_page_allocator.sv
verif/bitmap_page_allocator_tb.sv
